>>> rtl/core/ssalu_pkg.sv
// ----------------------------------------------------------------------------
// ssalu_pkg
// Shared opcodes, status codes, pipeline stage type and the radix-2 divide
// step used by the saturating signed ALU.
// ----------------------------------------------------------------------------
package ssalu_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned DIV_STEPS = DATA_W;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_NEG = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_REM = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]        opc;
    logic [DATA_W-1:0] res;
    logic [1:0]        st;
    logic              neg_a;
    logic              neg_q;
    logic              dz;
    logic              ovf;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] ub;
  } stage_t;

  // One restoring division step: shift in the next dividend bit and subtract
  // the divisor when it fits.
  function automatic stage_t div_step(input stage_t s);
    stage_t          o;
    logic [DATA_W:0] t;
    logic [DATA_W:0] d;
    logic            fit;
    o   = s;
    t   = {s.rem, s.quo[DATA_W-1]};
    d   = t - {1'b0, s.ub};
    fit = (t >= {1'b0, s.ub});
    o.rem = fit ? d[DATA_W-1:0] : t[DATA_W-1:0];
    o.quo = {s.quo[DATA_W-2:0], fit};
    return o;
  endfunction

endpackage

>>> rtl/core/ssalu_mul.sv
// ----------------------------------------------------------------------------
// ssalu_mul
// Two-stage unsigned 64x64 multiplier built from 32x32 partial products,
// with signed saturation applied on the output.
// ----------------------------------------------------------------------------
module ssalu_mul
  import ssalu_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] ua,
  input  logic [DATA_W-1:0] ub,
  input  logic              neg,
  output logic [DATA_W-1:0] res,
  output logic [1:0]        st
);

  localparam int unsigned HW = DATA_W / 2;

  logic [DATA_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic              neg1_r;
  logic              hi_nz_r;
  logic [DATA_W-1:0] lo_r;
  logic              neg2_r;

  logic [HW+1:0]     mid;
  logic [DATA_W-1:0] hi;
  logic [DATA_W-1:0] lo_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r  <= ua[HW-1:0] * ub[HW-1:0];
      p01_r  <= ua[HW-1:0] * ub[DATA_W-1:HW];
      p10_r  <= ua[DATA_W-1:HW] * ub[HW-1:0];
      p11_r  <= ua[DATA_W-1:HW] * ub[DATA_W-1:HW];
      neg1_r <= neg;
    end
  end

  always_comb begin
    mid    = {2'b00, p00_r[DATA_W-1:HW]} + {2'b00, p01_r[HW-1:0]} + {2'b00, p10_r[HW-1:0]};
    lo_nxt = {mid[HW-1:0], p00_r[HW-1:0]};
    hi     = p11_r + {{HW{1'b0}}, p01_r[DATA_W-1:HW]} + {{HW{1'b0}}, p10_r[DATA_W-1:HW]}
           + {{(DATA_W-2){1'b0}}, mid[HW+1:HW]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_nz_r <= |hi;
      lo_r    <= lo_nxt;
      neg2_r  <= neg1_r;
    end
  end

  always_comb begin
    if (!neg2_r) begin
      if (hi_nz_r || lo_r[DATA_W-1]) begin
        res = S_MAX;
        st  = ST_OVER;
      end else begin
        res = lo_r;
        st  = ST_OK;
      end
    end else begin
      if (hi_nz_r || (lo_r[DATA_W-1] && (|lo_r[DATA_W-2:0]))) begin
        res = S_MIN;
        st  = ST_UNDER;
      end else begin
        res = {DATA_W{1'b0}} - lo_r;
        st  = ST_OK;
      end
    end
  end

endmodule

>>> rtl/core/saturating_signed_alu64.sv
// ----------------------------------------------------------------------------
// saturating_signed_alu64
// Pipelined saturating signed 64-bit ALU: add, subtract, negate, multiply,
// divide and remainder with status.
// ----------------------------------------------------------------------------
// An accepted request passes through the input stage, the divide stages and the output register on its way out.
// Throughput is one request per cycle while the output is not stalled; the 64 one-bit
// divide steps set the depth, and every operation travels through the same stages.
// The whole pipeline holds while a result waits on a stalled output.
// Synchronous active-low reset clears all valid bits.
module saturating_signed_alu64
  import ssalu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_opcode,
  input  logic signed [DATA_W-1:0] in_operand_a,
  input  logic signed [DATA_W-1:0] in_operand_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_result,
  output logic [1:0]               out_status
);

  logic en;

  stage_t            dv_r  [0:DIV_STEPS];
  logic              vld_r [0:DIV_STEPS];
  stage_t            s0_nxt;

  logic              out_vld_r;
  logic [DATA_W-1:0] out_res_r, out_res_nxt;
  logic [1:0]        out_st_r, out_st_nxt;

  logic [DATA_W-1:0] a, b, x, y, sum;
  logic              is_sub;
  logic [DATA_W-1:0] mul_res;
  logic [1:0]        mul_st;

  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;

  always_comb begin
    a      = in_operand_a;
    b      = in_operand_b;
    is_sub = (in_opcode != OP_ADD);
    x      = (in_opcode == OP_NEG) ? {DATA_W{1'b0}} : a;
    y      = (in_opcode == OP_NEG) ? a : b;
    sum    = is_sub ? (x - y) : (x + y);

    s0_nxt       = '0;
    s0_nxt.opc   = in_opcode;
    s0_nxt.neg_a = a[DATA_W-1];
    s0_nxt.neg_q = a[DATA_W-1] ^ b[DATA_W-1];
    s0_nxt.dz    = (b == {DATA_W{1'b0}});
    s0_nxt.ovf   = (a == S_MIN) && (b == {DATA_W{1'b1}});
    s0_nxt.rem   = {DATA_W{1'b0}};
    s0_nxt.quo   = a[DATA_W-1] ? ({DATA_W{1'b0}} - a) : a;
    s0_nxt.ub    = b[DATA_W-1] ? ({DATA_W{1'b0}} - b) : b;
    s0_nxt.res   = {DATA_W{1'b0}};
    s0_nxt.st    = ST_OK;
    case (in_opcode) inside
      OP_ADD, OP_SUB, OP_NEG: begin
        s0_nxt.res = sum;
        if (((x[DATA_W-1] == y[DATA_W-1]) != is_sub)
            && (sum[DATA_W-1] != x[DATA_W-1])) begin
          s0_nxt.res = x[DATA_W-1] ? S_MIN : S_MAX;
          s0_nxt.st  = x[DATA_W-1] ? ST_UNDER : ST_OVER;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      dv_r[0]  <= s0_nxt;
    end
  end

  ssalu_mul u_mul (
    .clk (clk),
    .en  (en),
    .ua  (dv_r[0].quo),
    .ub  (dv_r[0].ub),
    .neg (dv_r[0].neg_q),
    .res (mul_res),
    .st  (mul_st)
  );

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    stage_t nxt;
    always_comb begin
      nxt = div_step(dv_r[k-1]);
      if ((k == 3) && (dv_r[k-1].opc == OP_MUL)) begin
        nxt.res = mul_res;
        nxt.st  = mul_st;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
        dv_r[k]  <= nxt;
      end
    end
  end

  always_comb begin
    out_res_nxt = dv_r[DIV_STEPS].res;
    out_st_nxt  = dv_r[DIV_STEPS].st;
    if ((dv_r[DIV_STEPS].opc == OP_DIV) || (dv_r[DIV_STEPS].opc == OP_REM)) begin
      if (dv_r[DIV_STEPS].dz) begin
        out_res_nxt = {DATA_W{1'b0}};
        out_st_nxt  = ST_DIVZ;
      end else if (dv_r[DIV_STEPS].ovf) begin
        out_res_nxt = S_MIN;
        out_st_nxt  = ST_OVER;
      end else if (dv_r[DIV_STEPS].opc == OP_DIV) begin
        out_res_nxt = dv_r[DIV_STEPS].neg_q ? ({DATA_W{1'b0}} - dv_r[DIV_STEPS].quo)
                                            : dv_r[DIV_STEPS].quo;
        out_st_nxt  = ST_OK;
      end else begin
        out_res_nxt = dv_r[DIV_STEPS].neg_a ? ({DATA_W{1'b0}} - dv_r[DIV_STEPS].rem)
                                            : dv_r[DIV_STEPS].rem;
        out_st_nxt  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[DIV_STEPS];
      out_res_r <= out_res_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_result = out_res_r;
  assign out_status = out_st_r;

endmodule

>>> verif/saturating_signed_alu64_test.sv
// ----------------------------------------------------------------------------
// saturating_signed_alu64_test
// Self-checking testbench for the saturating signed 64-bit ALU. Each request
// is predicted as it is accepted and checked in order against the results.
// A directed set of edge cases comes first, followed by random requests.
// Both handshakes idle at random, and the output holds off once for a long
// stretch so that the pipeline fills.
// ----------------------------------------------------------------------------
module saturating_signed_alu64_test;
  import ssalu_pkg::*;

  typedef struct packed {
    logic [2:0]        opc;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic [1:0]        st;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_opcode;
  logic signed [DATA_W-1:0] in_operand_a;
  logic signed [DATA_W-1:0] in_operand_b;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] out_result;
  logic [1:0] out_status;

  request_t pending_q[$];
  outcome_t outcome_q[$];
  int       error_count = 0;
  int       tx_gap = 0;
  int       rx_gap = 0;
  int       hold_cycles = 0;
  bit       hold_done = 0;
  bit       long_hold = 0;
  int       rx_count = 0;

  saturating_signed_alu64 u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result(out_result), .out_status(out_status)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] abs_val(logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? -v : v;
  endfunction

  function automatic outcome_t alu_predict(request_t r);
    outcome_t          o;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] s;
    logic [2*DATA_W-1:0] p;
    logic              neg;
    o.res = '0;
    o.st  = ST_OK;
    x = r.a;
    y = r.b;
    case (r.opc) inside
      OP_ADD, OP_SUB, OP_NEG: begin
        if (r.opc == OP_NEG) begin
          x = '0;
          y = r.a;
        end
        if (r.opc == OP_ADD) begin
          s = x + y;
          neg = (x[DATA_W-1] == y[DATA_W-1]);
        end else begin
          s = x - y;
          neg = (x[DATA_W-1] != y[DATA_W-1]);
        end
        o.res = s;
        if (neg && s[DATA_W-1] != x[DATA_W-1]) begin
          o.res = x[DATA_W-1] ? S_MIN : S_MAX;
          o.st  = x[DATA_W-1] ? ST_UNDER : ST_OVER;
        end
      end
      OP_MUL: begin
        neg = x[DATA_W-1] ^ y[DATA_W-1];
        p = {{DATA_W{1'b0}}, abs_val(x)} * {{DATA_W{1'b0}}, abs_val(y)};
        if (!neg) begin
          if (p > {{DATA_W{1'b0}}, S_MAX}) begin
            o.res = S_MAX;
            o.st  = ST_OVER;
          end else o.res = p[DATA_W-1:0];
        end else begin
          if (p > {{DATA_W{1'b0}}, S_MIN}) begin
            o.res = S_MIN;
            o.st  = ST_UNDER;
          end else o.res = -p[DATA_W-1:0];
        end
      end
      OP_DIV, OP_REM: begin
        if (y == '0) o.st = ST_DIVZ;
        else if (x == S_MIN && y == '1) begin
          o.res = S_MIN;
          o.st  = ST_OVER;
        end else if (r.opc == OP_DIV) begin
          s = abs_val(x) / abs_val(y);
          o.res = (x[DATA_W-1] ^ y[DATA_W-1]) ? -s : s;
        end else begin
          s = abs_val(x) % abs_val(y);
          o.res = x[DATA_W-1] ? -s : s;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic logic [DATA_W-1:0] rand_operand();
    logic [DATA_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = S_MAX - $urandom_range(0, 2);
      1: v = S_MIN + $urandom_range(0, 2);
      2: v = DATA_W'(int'($urandom_range(0, 4)) - 2);
      3: v = {{32{v[31]}}, v[31:0]};
      4: v = {{48{v[15]}}, v[15:0]};
      default: ;
    endcase
    return v;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) outcome_q.push_back(alu_predict({in_opcode, in_operand_a,
                                                     in_operand_b}));
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 0;
      end else if (pending_q.size() > 0) begin
        request_t r;
        r = pending_q.pop_front();
        in_valid <= 1;
        in_opcode <= r.opc;
        in_operand_a <= r.a;
        in_operand_b <= r.b;
        tx_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
      end else in_valid <= 0;
    end
  end

  // Long hold-off of the output, started once after 100 results.
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold <= 0;
    end else if (!hold_done && rx_count >= 100) begin
      hold_done <= 1;
      hold_cycles <= 300;
      long_hold <= 1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      long_hold <= (hold_cycles > 1);
    end
  end

  // Result monitor and output stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        outcome_t w;
        rx_count++;
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result", out_result, '0);
        end else begin
          w = outcome_q.pop_front();
          if (out_result !== w.res) report_mismatch("result", out_result, w.res);
          if (out_status !== w.st) report_mismatch("status", DATA_W'(out_status),
                                                   DATA_W'(w.st));
        end
      end
      if (long_hold) begin
        out_stall <= 1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
        if ($urandom_range(0, 3) == 0) rx_gap <= $urandom_range(0, 7);
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] edge_vals[6];
    request_t r;
    edge_vals = '{S_MAX, S_MIN, '0, 64'd1, '1, 64'd2};
    rst_n = 0;
    in_valid = 0;
    in_opcode = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    out_stall = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    for (int op = 0; op < 8; op++) begin
      for (int k = 0; k < 3; k++) begin
        r.opc = 3'(op);
        r.a = edge_vals[k * 2 % 6];
        r.b = edge_vals[(k * 2 + 3 + op) % 6];
        pending_q.push_back(r);
      end
    end
    r = '{OP_NEG, S_MIN, '0};
    pending_q.push_back(r);
    r = '{OP_DIV, S_MIN, '1};
    pending_q.push_back(r);
    r = '{OP_REM, S_MIN, '1};
    pending_q.push_back(r);
    for (int i = 0; i < 800; i++) begin
      r.opc = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
      r.a = rand_operand();
      r.b = ($urandom_range(0, 19) == 0) ? '0 : rand_operand();
      pending_q.push_back(r);
    end
    while (pending_q.size() > 0 || in_valid) @(posedge clk);
    while (outcome_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (error_count == 0) $display("saturating_signed_alu64_test OK");
    else $display("saturating_signed_alu64_test NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("saturating_signed_alu64_test NOT OK");
    $finish;
  end

endmodule
